// File: design/mavt_pkg.sv
// Shared constants, types and register codes for the multiturn angle and velocity tracker.
`default_nettype none

package mavt_pkg;

  localparam int RAW_BITS      = 14;
  localparam int TURN_BITS     = 24;
  localparam int TIMER_BITS    = 16;
  localparam int FALLBACK_BITS = 16;
  localparam int ANGLE_BITS    = 38;
  localparam int VEL_BITS      = 32;
  localparam int FRAC_BITS     = 16;

  localparam int DIV_STEPS     = ANGLE_BITS + FRAC_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);
  localparam int QUO_BITS      = VEL_BITS + 1;

  localparam int IN_DATA_W     = ((RAW_BITS + TIMER_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W    = ((ANGLE_BITS + VEL_BITS + 7) / 8) * 8;

  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [RAW_BITS-1:0]      HOME_POS_RST       = RAW_BITS'(0);
  localparam logic [RAW_BITS-1:0]      WRAP_THRESHOLD_RST = RAW_BITS'(13107);
  localparam logic [FALLBACK_BITS-1:0] FALLBACK_TICKS_RST = FALLBACK_BITS'(1000);

  typedef enum logic [1:0] {
    REG_HOME_POS       = 2'd0,
    REG_WRAP_THRESHOLD = 2'd1,
    REG_FALLBACK_TICKS = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TURN,
    ST_ANGLE,
    ST_DIFF,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } mavt_state_e;

  typedef struct packed {
    logic [RAW_BITS-1:0]      home_pos;
    logic [RAW_BITS-1:0]      wrap_threshold;
    logic [FALLBACK_BITS-1:0] fallback_ticks;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic turn;
    logic angle;
    logic diff;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic item_primed;
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

// File: design/multiturn_angle_velocity_tracker_unit.sv
// Top level of the multiturn angle and velocity tracker: stream ports, register file and core.
// A primed sample passes the turn, angle, difference and divider-load states and the
//   54-step divider; the first sample after reset only primes the history and skips the
//   difference and division. A new sample is taken only once the previous one is loaded.
// Reset: rst_ni clears the turn count, the stored angle, the primed flag and any pending
//   result, and returns the registers to their default values.
`default_nettype none

module multiturn_angle_velocity_tracker_unit (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Input stream. tdata: raw_angle [13:0], timer_count [29:14], zero pad above.
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic [mavt_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  // Output stream. tdata: angle_counts [37:0], velocity_q16 [69:38], zero pad above.
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic [mavt_pkg::OUT_DATA_W-1:0]            m_axis_tdata,
  // tuser: turn_changed [0].
  output logic [0:0]                                 m_axis_tuser,
  // Register port.
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [mavt_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  wire logic [mavt_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [mavt_pkg::CFG_DATA_BITS-1:0]         prdata,
  output logic                                       pready
);
  import mavt_pkg::*;

  // The register file: each register keeps only its low bits.
  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.home_pos       <= HOME_POS_RST;
      cfg_q.wrap_threshold <= WRAP_THRESHOLD_RST;
      cfg_q.fallback_ticks <= FALLBACK_TICKS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HOME_POS:       cfg_q.home_pos       <= pwdata[RAW_BITS-1:0];
        REG_WRAP_THRESHOLD: cfg_q.wrap_threshold <= pwdata[RAW_BITS-1:0];
        REG_FALLBACK_TICKS: cfg_q.fallback_ticks <= pwdata[FALLBACK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Reads of the unused address return zero.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_HOME_POS:       prdata = CFG_DATA_BITS'(cfg_q.home_pos);
      REG_WRAP_THRESHOLD: prdata = CFG_DATA_BITS'(cfg_q.wrap_threshold);
      REG_FALLBACK_TICKS: prdata = CFG_DATA_BITS'(cfg_q.fallback_ticks);
      default:            prdata = '0;
    endcase
  end

  // The controller takes one sample at a time; the finished result waits in the output
  // register, so a new sample can be taken while the previous result is still unclaimed.
  cmd_t    cmd;
  status_t status;

  mavt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  logic [ANGLE_BITS-1:0] angle_counts;
  logic [VEL_BITS-1:0]   velocity_q16;
  logic                  turn_changed;

  mavt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .status_o       (status),
    .raw_angle_i    (s_axis_tdata[RAW_BITS-1:0]),
    .timer_count_i  (s_axis_tdata[RAW_BITS+TIMER_BITS-1:RAW_BITS]),
    .angle_counts_o (angle_counts),
    .velocity_q16_o (velocity_q16),
    .turn_changed_o (turn_changed)
  );

  assign m_axis_tdata = OUT_DATA_W'({velocity_q16, angle_counts});
  assign m_axis_tuser = turn_changed;

endmodule

`default_nettype wire

// File: design/mavt_ctrl.sv
// Controller state machine: sequences one item through unwrap and, if primed, difference and division.
`default_nettype none

module mavt_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire mavt_pkg::status_t status_i,
  output mavt_pkg::cmd_t      cmd_o
);
  import mavt_pkg::*;

  mavt_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_TURN;
      ST_TURN:  state_d = ST_ANGLE;
      ST_ANGLE: state_d = status_i.item_primed ? ST_DIFF : ST_FIN;
      ST_DIFF:  state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_DIV;
      ST_DIV:   if (status_i.div_last) state_d = ST_FIN;
      ST_FIN:   if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_TURN:  cmd_o.turn     = 1'b1;
      ST_ANGLE: cmd_o.angle    = 1'b1;
      ST_DIFF:  cmd_o.diff     = 1'b1;
      ST_LOAD:  cmd_o.div_load = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_FIN:   cmd_o.out_load = slot_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: design/mavt_dp.sv
// Datapath: turn counting, angle unwrap, angle difference and serial restoring divider.
`default_nettype none

module mavt_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mavt_pkg::cfg_t                    cfg_i,
  input  wire mavt_pkg::cmd_t                    cmd_i,
  output mavt_pkg::status_t                      status_o,
  input  wire logic [mavt_pkg::RAW_BITS-1:0]     raw_angle_i,
  input  wire logic [mavt_pkg::TIMER_BITS-1:0]   timer_count_i,
  output logic [mavt_pkg::ANGLE_BITS-1:0]        angle_counts_o,
  output logic [mavt_pkg::VEL_BITS-1:0]          velocity_q16_o,
  output logic                                   turn_changed_o
);
  import mavt_pkg::*;

  localparam logic [VEL_BITS-1:0] VEL_MAX = {1'b0, {(VEL_BITS-1){1'b1}}};
  localparam logic [VEL_BITS-1:0] VEL_MIN = {1'b1, {(VEL_BITS-1){1'b0}}};

  // Captured item and persistent tracking state.
  logic [RAW_BITS-1:0]   raw_q;
  logic [TIMER_BITS-1:0] now_q;
  logic [RAW_BITS-1:0]   prev_raw_q;
  logic [TIMER_BITS-1:0] prev_time_q;
  logic [TURN_BITS-1:0]  turn_q, turn_d;
  logic [ANGLE_BITS-1:0] prev_angle_q;
  logic                  primed_q;
  logic                  item_primed_q;

  // Per-item working registers.
  logic                  changed_q, changed_d;
  logic [TIMER_BITS-1:0] ticks_q, ticks_d;
  logic [ANGLE_BITS-1:0] angle_q, angle_d;
  logic [ANGLE_BITS-1:0] diff_q;

  // Divider.
  logic [DIV_STEPS-1:0]    dvd_q;
  logic [TIMER_BITS-1:0]   rem_q, rem_d;
  logic [QUO_BITS-1:0]     quo_q;
  logic                    ovf_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;

  // Output payload.
  logic [ANGLE_BITS-1:0] angle_out_q;
  logic [VEL_BITS-1:0]   vel_out_q, vel_d;
  logic                  changed_out_q;

  // Turn detection.
  logic [RAW_BITS:0] raw_delta;
  logic [RAW_BITS:0] raw_mag;
  logic              wrapped;
  logic [TIMER_BITS-1:0] elapsed;

  always_comb begin
    raw_delta = {1'b0, raw_q} - {1'b0, prev_raw_q};
    raw_mag   = raw_delta[RAW_BITS] ? (~raw_delta + 1'b1) : raw_delta;
    wrapped   = item_primed_q && (raw_mag > {1'b0, cfg_i.wrap_threshold});
    changed_d = wrapped;
    turn_d    = turn_q;
    if (wrapped) begin
      turn_d = raw_delta[RAW_BITS] ? (turn_q + 1'b1) : (turn_q - 1'b1);
    end
    elapsed = now_q - prev_time_q;
    ticks_d = elapsed;
    if (elapsed == '0) begin
      ticks_d = (cfg_i.fallback_ticks == '0) ? TIMER_BITS'(1)
                                             : TIMER_BITS'(cfg_i.fallback_ticks);
    end
  end

  // Unwrapped angle: whole turns shifted up by the raw width, plus raw, minus offset.
  logic signed [TURN_BITS-1:0] turn_s;
  logic [ANGLE_BITS-1:0]       turn_ext;

  always_comb begin
    turn_s   = turn_q;
    turn_ext = ANGLE_BITS'(turn_s) << RAW_BITS;
    angle_d  = turn_ext + ANGLE_BITS'(raw_q) - ANGLE_BITS'(cfg_i.home_pos);
  end

  // One restoring step per cycle: remainder stays below the divisor.
  logic [TIMER_BITS:0] trial;
  logic                fits;

  always_comb begin
    trial = {rem_q, dvd_q[DIV_STEPS-1]};
    fits  = trial >= {1'b0, ticks_q};
    rem_d = fits ? TIMER_BITS'(trial - {1'b0, ticks_q}) : trial[TIMER_BITS-1:0];
  end

  // Saturation of the magnitude quotient and sign restore.
  logic [ANGLE_BITS-1:0] diff_mag;
  logic                  neg;
  logic                  pos_big, neg_big;
  logic [VEL_BITS-1:0]   vel_mag;

  always_comb begin
    diff_mag = diff_q[ANGLE_BITS-1] ? (~diff_q + 1'b1) : diff_q;
    neg      = diff_q[ANGLE_BITS-1];
    pos_big  = ovf_q | quo_q[VEL_BITS] | quo_q[VEL_BITS-1];
    neg_big  = ovf_q | quo_q[VEL_BITS] | (quo_q[VEL_BITS-1] & (|quo_q[VEL_BITS-2:0]));
    vel_d    = '0;
    vel_mag  = quo_q[VEL_BITS-1:0];
    if (item_primed_q) begin
      if (neg) begin
        if (neg_big) vel_mag = VEL_MIN;
        vel_d = ~vel_mag + 1'b1;
      end else begin
        vel_d = pos_big ? VEL_MAX : vel_mag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_q       <= '0;
      prev_angle_q <= '0;
      primed_q     <= 1'b0;
    end else begin
      if (cmd_i.turn) begin
        turn_q   <= turn_d;
        primed_q <= 1'b1;
      end
      if (cmd_i.diff) begin
        prev_angle_q <= angle_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      raw_q         <= raw_angle_i;
      now_q         <= timer_count_i;
      item_primed_q <= primed_q;
    end
    if (cmd_i.turn) begin
      changed_q   <= changed_d;
      ticks_q     <= ticks_d;
      prev_raw_q  <= raw_q;
      prev_time_q <= now_q;
    end
    if (cmd_i.angle) begin
      angle_q <= angle_d;
    end
    if (cmd_i.diff) begin
      diff_q <= angle_q - prev_angle_q;
    end
    if (cmd_i.div_load) begin
      dvd_q <= {diff_mag, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
      cnt_q <= DIV_CNT_BITS'(DIV_STEPS - 1);
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
      quo_q <= {quo_q[QUO_BITS-2:0], fits};
      ovf_q <= ovf_q | quo_q[QUO_BITS-1];
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.out_load) begin
      angle_out_q   <= angle_q;
      vel_out_q     <= vel_d;
      changed_out_q <= changed_q;
    end
  end

  assign status_o.item_primed = item_primed_q;
  assign status_o.div_last    = (cnt_q == '0);

  assign angle_counts_o = angle_out_q;
  assign velocity_q16_o = vel_out_q;
  assign turn_changed_o = changed_out_q;

endmodule

`default_nettype wire

// File: design/mavt_checker.sv
// Port-level checker for the tracker, bound to the top level.
`default_nettype none

module mavt_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               s_axis_tvalid,
  input wire logic                               s_axis_tready,
  input wire logic                               m_axis_tvalid,
  input wire logic                               m_axis_tready,
  input wire logic [mavt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input wire logic [0:0]                         m_axis_tuser,
  input wire logic                               psel,
  input wire logic                               penable,
  input wire logic                               pready
);
  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // A stalled result holds its payload until the transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // One sample at a time: the input side closes straight after a transfer.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("input still open after a transfer");

  // The input side closes only because a sample was taken.
  a_close_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(in_xfer))
    else $error("input closed without a transfer");

  // The register port never inserts wait states.
  a_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("register access stalled");

endmodule

bind multiturn_angle_velocity_tracker_unit mavt_checker u_mavt_checker (.*);

`default_nettype wire
